// ===== design/assert_macros.svh =====
// Assertion macros shared by the FIR filter RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When ante holds, cons holds in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// When ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fir_ob_pkg.sv =====
// Package for the offset-binary FIR filter: widths, reset values, register
// indexes and the control struct between the top level and the tap cells. No dependencies.
package fir_ob_pkg;

   localparam int MAX_TAPS_DEF    = 7;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int NUM_COEFS       = 7;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = 32;
   localparam int ACC_W      = 35;
   localparam int TAP_W      = 3;
   localparam int FRAC_BITS  = 15;
   localparam int ROUND_HALF = 16384;
   localparam int OUT_MAX    = 32767;
   localparam int OUT_MIN    = -32768;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [TAP_W-1:0] TAP_COUNT_RST = 3'd5;
   localparam logic signed [COEF_W-1:0] COEF_RST [NUM_COEFS] = '{
      16'sd6554, 16'sd6554, 16'sd6554, 16'sd6554, 16'sd6554, 16'sd0, 16'sd0
   };

   typedef enum logic [2:0] {
      REG_TAP_COUNT = 3'd0,
      REG_COEF_0    = 3'd1,
      REG_COEF_1    = 3'd2,
      REG_COEF_2    = 3'd3,
      REG_COEF_3    = 3'd4,
      REG_COEF_4    = 3'd5,
      REG_COEF_5    = 3'd6,
      REG_COEF_6    = 3'd7
   } reg_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

   typedef struct packed {
      logic shift;    // an item was accepted: the window moves one cell
      logic clear;    // record start: the cell takes zero instead of its neighbor
      logic prod_en;  // the product stage takes the current window
   } cell_ctrl_type;

endpackage

// ===== design/fir_ob_cell.sv =====
// One tap cell of the FIR filter: a window sample and its registered product.
// Depends on fir_ob_pkg.
module fir_ob_cell
   import fir_ob_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  sample_type    prev_sample,
   input  coef_type      coef,
   output sample_type    sample,
   output prod_type      product
);

   sample_type sample_ff, sample_in;
   prod_type   product_ff, product_in;

   always_comb begin
      sample_in  = ctrl.clear ? '0 : prev_sample;
      product_in = sample_ff * coef;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (ctrl.shift) begin
         sample_ff <= sample_in;
      end
      if (ctrl.prod_en) begin
         product_ff <= product_in;
      end
   end

   assign sample  = sample_ff;
   assign product = product_ff;

endmodule

// ===== design/fir_ob_sum.sv =====
// Registered adder tree, rounding and saturation of the tap products, with
// the output register. Depends on fir_ob_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fir_ob_sum
   import fir_ob_pkg::*;
#(
   parameter int MAX_TAPS = MAX_TAPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  prod_type                 products [MAX_TAPS],
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_filtered,
   output logic                     rsp_clipped
);

   localparam int NUM_PAIRS = (MAX_TAPS + 1) / 2;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SCALE_W   = ACC_W + 1 - FRAC_BITS;

   localparam logic signed [SCALE_W-1:0]  SCALE_MAX = SCALE_W'(OUT_MAX);
   localparam logic signed [SCALE_W-1:0]  SCALE_MIN = SCALE_W'(OUT_MIN);
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX   = SAMPLE_W'(OUT_MAX);
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN   = SAMPLE_W'(OUT_MIN);

   logic signed [PAIR_W-1:0] pair_ff [NUM_PAIRS];
   logic signed [PAIR_W-1:0] pair_in [NUM_PAIRS];
   logic signed [ACC_W-1:0]  total_ff, total_in;
   logic signed [ACC_W:0]    biased;
   logic signed [SCALE_W-1:0] scaled;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff, rsp_filtered_in;
   logic rsp_clipped_ff, rsp_clipped_in;
   logic pair_valid_ff, pair_valid_in;
   logic total_valid_ff, total_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic take_pair, take_total, take_out;

   // Bubbles collapse: a stage loads whenever it is empty or moves on.
   always_comb begin
      take_out   = total_valid_ff && (!rsp_valid_ff || !rsp_stall);
      take_total = pair_valid_ff && (!total_valid_ff || take_out);
      in_stall   = pair_valid_ff && total_valid_ff && rsp_valid_ff && rsp_stall;
      take_pair  = in_valid && !in_stall;

      pair_valid_in  = take_pair || (pair_valid_ff && !take_total);
      total_valid_in = take_total || (total_valid_ff && !take_out);
      rsp_valid_in   = take_out || (rsp_valid_ff && rsp_stall);
   end

   for (genvar i = 0; i < NUM_PAIRS; i++) begin : g_pair
      if (2 * i + 1 < MAX_TAPS) begin : g_two
         assign pair_in[i] = PAIR_W'(products[2*i]) + PAIR_W'(products[2*i+1]);
      end else begin : g_one
         assign pair_in[i] = PAIR_W'(products[2*i]);
      end
   end

   always_comb begin
      total_in = '0;
      for (int i = 0; i < NUM_PAIRS; i++) begin
         total_in = total_in + ACC_W'(pair_ff[i]);
      end
   end

   // Round half up: add half an output LSB, then drop the fraction bits.
   always_comb begin
      biased = (ACC_W + 1)'(total_ff) + (ACC_W + 1)'(ROUND_HALF);
      scaled = biased[ACC_W:FRAC_BITS];
      if (scaled > SCALE_MAX) begin
         rsp_filtered_in = SAT_MAX;
         rsp_clipped_in  = 1'b1;
      end else if (scaled < SCALE_MIN) begin
         rsp_filtered_in = SAT_MIN;
         rsp_clipped_in  = 1'b1;
      end else begin
         rsp_filtered_in = scaled[SAMPLE_W-1:0];
         rsp_clipped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff  <= 1'b0;
         total_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pair_valid_ff  <= pair_valid_in;
         total_valid_ff <= total_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (take_pair) begin
         pair_ff <= pair_in;
      end
      if (take_total) begin
         total_ff <= total_in;
      end
      if (take_out) begin
         rsp_filtered_ff <= rsp_filtered_in;
         rsp_clipped_ff  <= rsp_clipped_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_clipped  = rsp_clipped_ff;

   `ASSERT_IMPLIES(clip_at_rail_a, rsp_valid_ff && rsp_clipped_ff, rsp_filtered_ff == SAT_MAX || rsp_filtered_ff == SAT_MIN, "clipped item is not at a rail")

endmodule

// ===== design/fir_filter_offset_binary_samples_top.sv =====
// Top level of the offset-binary FIR filter: register port, sample window
// control and the row of tap cells. Depends on fir_ob_pkg, fir_ob_cell, fir_ob_sum.
//
//   Channel   Direction  Handshake           Payload
//   req_      in         req_valid/stall     raw_sample, record_start
//   rsp_      out        rsp_valid/stall     filtered, clipped
//   csr_      in/out     APB psel/penable    tap_count, coef_0 .. coef_6
//
// One sample is taken every cycle while req_stall is low; a result passes from
// its sample through the product, pair-sum, total and output registers.
// Reset empties the window at once; there is no clearing pass.
// Empty stages absorb a downstream stall, so req_stall rises only when rsp_stall
// is high and every stage from the window cells to the output register holds an item.
`include "assert_macros.svh"
module fir_filter_offset_binary_samples_top
   import fir_ob_pkg::*;
#(
   parameter int MAX_TAPS    = MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_W-1:0]       req_raw_sample,
   input  logic                      req_record_start,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_filtered,
   output logic                      rsp_clipped,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   localparam int FILL_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS + 1) : 1;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_TAPS);
   localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);
   localparam logic [SAMPLE_BITS-1:0] HALF_SCALE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

   logic [TAP_W-1:0] tap_count_ff;
   coef_type         coef_ff [NUM_COEFS];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic accept, adv1, adv2, produce, sum_stall, csr_write;
   logic [TAP_W:0] taps;
   logic [SAMPLE_BITS-1:0] centered;
   sample_type new_sample;
   reg_index_type reg_idx;

   cell_ctrl_type cell_ctrl   [MAX_TAPS];
   sample_type    cell_prev   [MAX_TAPS];
   sample_type    cell_sample [MAX_TAPS];
   coef_type      cell_coef   [MAX_TAPS];
   prod_type      cell_prod   [MAX_TAPS];

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      if (reg_idx == REG_TAP_COUNT) begin
         csr_prdata = CSR_DATA_W'(tap_count_ff);
      end else begin
         csr_prdata = CSR_DATA_W'(unsigned'(coef_ff[3'(reg_idx - REG_COEF_0)]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RST;
         coef_ff      <= COEF_RST;
      end else if (csr_write) begin
         if (reg_idx == REG_TAP_COUNT) begin
            tap_count_ff <= csr_pwdata[TAP_W-1:0];
         end else begin
            coef_ff[3'(reg_idx - REG_COEF_0)] <= csr_pwdata[COEF_W-1:0];
         end
      end
   end

   // A tap count of zero means one tap; counts past the window are clamped.
   always_comb begin
      if (tap_count_ff == '0) begin
         taps = (TAP_W + 1)'(1);
      end else if ((TAP_W + 1)'(tap_count_ff) > (TAP_W + 1)'(MAX_TAPS)) begin
         taps = (TAP_W + 1)'(MAX_TAPS);
      end else begin
         taps = (TAP_W + 1)'(tap_count_ff);
      end
   end

   // Offset binary to two's complement: flip the top bit, then left-align.
   assign centered   = req_raw_sample[SAMPLE_BITS-1:0] ^ HALF_SCALE;
   assign new_sample = sample_type'(SAMPLE_W'(centered) << (SAMPLE_W - SAMPLE_BITS));

   // Pipeline control: the window cells form the first stage, the product
   // registers the second.
   always_comb begin
      adv2      = v2_ff && !sum_stall;
      adv1      = v1_ff && (!v2_ff || adv2);
      req_stall = v1_ff && v2_ff && sum_stall;
      accept    = req_valid && !req_stall;

      if (req_record_start) begin
         fill_in = FILL_ONE;
      end else if (fill_ff < FILL_MAX) begin
         fill_in = fill_ff + FILL_ONE;
      end else begin
         fill_in = fill_ff;
      end
      produce = (TAP_W + 1)'(fill_in) >= taps;

      v1_in = (accept && produce) || (v1_ff && !adv1);
      v2_in = adv1 || (v2_ff && !adv2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff <= fill_in;
         end
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // Cell k holds the k-th newest sample and meets coefficient taps-1-k.
   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      localparam logic [TAP_W:0] K = (TAP_W + 1)'(k);

      assign cell_ctrl[k].shift   = accept;
      assign cell_ctrl[k].clear   = (k > 0) ? req_record_start : 1'b0;
      assign cell_ctrl[k].prod_en = adv1;
      assign cell_prev[k]         = (k > 0) ? cell_sample[(k > 0) ? k - 1 : 0] : new_sample;
      assign cell_coef[k] = (K < taps) ? coef_ff[TAP_W'(taps - K - (TAP_W + 1)'(1))] : '0;

      fir_ob_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[k]),
         .prev_sample (cell_prev[k]),
         .coef        (cell_coef[k]),
         .sample      (cell_sample[k]),
         .product     (cell_prod[k])
      );
   end

   fir_ob_sum #(
      .MAX_TAPS (MAX_TAPS)
   ) u_sum (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v2_ff),
      .in_stall     (sum_stall),
      .products     (cell_prod),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered),
      .rsp_clipped  (rsp_clipped)
   );

   `ASSERT_NEXT(record_start_fill_a, accept && req_record_start, fill_ff == FILL_ONE, "window not restarted")
   `ASSERT_NEXT(fill_step_a, accept && !req_record_start && fill_ff < FILL_MAX, fill_ff == $past(fill_ff) + FILL_ONE, "fill count did not advance")
   `ASSERT_IMPLIES(window_busy_a, v1_ff && accept, adv1, "window overwritten before its products were taken")

endmodule
